[hw/rtl/lpc_pkg.sv]
// Shared constants, payload types and the bound helper of the lag power classifier.
// Used by the channel interfaces and by every classifier module.
package lpc_pkg;

    localparam int MAX_LAGS   = 64;
    localparam int LAG_W      = $clog2(MAX_LAGS);
    localparam int P_W        = 32;
    localparam int CODE_W     = 4;
    localparam int INV_W      = 17;
    localparam int BOUND_W    = 34;
    localparam int GC_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = P_W + INV_W;

    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [INV_W-1:0] INV_AVG_RST = 17'd65536;
    localparam logic [INV_W-1:0] INV_TWO_RST = 17'd46341;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_AVG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_TWO = 2'd2;

    localparam logic [CODE_W-1:0] CODE_GOOD       = 4'd0;
    localparam logic [CODE_W-1:0] CODE_LOW        = 4'd3;
    localparam logic [CODE_W-1:0] CODE_HIGH       = 4'd5;
    localparam logic [CODE_W-1:0] CODE_AFTER_LOWS = 4'd7;

    typedef struct packed {
        logic [P_W-1:0]   noise_level;
        logic [INV_W-1:0] inv_sqrt_averages;
        logic [INV_W-1:0] inv_sqrt_two_averages;
    } t_cfg;

    typedef struct packed {
        logic [P_W-1:0]    power;
        logic [CODE_W-1:0] preset_code;
        logic              last;
        logic [LAG_W-1:0]  idx;
    } t_lag;

    typedef struct packed {
        logic [P_W-1:0]    power;
        logic [CODE_W-1:0] preset_code;
        logic              last;
        logic [LAG_W-1:0]  idx;
        logic [P_W-1:0]    floor;
        logic [P_W-1:0]    offset;
    } t_stage;

    typedef struct packed {
        logic [LAG_W-1:0]       lag_index;
        logic [CODE_W-1:0]      code;
        logic                   revise_valid;
        logic [LAG_W-1:0]       revise_lag;
        logic signed [GC_W-1:0] good_count;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic    a_valid;
        t_result a;
        logic    b_valid;
        t_result b;
    } t_push;

    // 2*noise + power + offset tops out below 2^34, so no clamp is needed
    function automatic logic [BOUND_W-1:0] make_bound(input logic [P_W-1:0] noise,
                                                      input logic [P_W-1:0] power,
                                                      input logic [P_W-1:0] offset);
        return {1'b0, noise, 1'b0} + {2'b00, power} + {2'b00, offset};
    endfunction

endpackage

[hw/rtl/lpc_if.sv]
// Valid/ready channel interfaces: lag requests in, results out, register writes.
// Depends on lpc_pkg for field widths.
interface lpc_lag_if;
    import lpc_pkg::*;
    logic              valid;
    logic              ready;
    logic [P_W-1:0]    power;
    logic [CODE_W-1:0] preset_code;
    logic              last_lag;
    modport source (output valid, power, preset_code, last_lag, input ready);
    modport sink   (input valid, power, preset_code, last_lag, output ready);
endinterface

interface lpc_res_if;
    import lpc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [LAG_W-1:0]       lag_index;
    logic [CODE_W-1:0]      code;
    logic                   revise_valid;
    logic [LAG_W-1:0]       revise_lag;
    logic signed [GC_W-1:0] good_count;
    logic                   last;
    modport source (output valid, lag_index, code, revise_valid, revise_lag, good_count, last,
                    input ready);
    modport sink   (input valid, lag_index, code, revise_valid, revise_lag, good_count, last,
                    output ready);
endinterface

interface lpc_cfg_if;
    import lpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/lpc_cfg_regs.sv]
// Configuration registers: noise level and the two Q1.16 reciprocal roots.
// Depends on lpc_pkg and lpc_cfg_if.
module lpc_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpc_cfg_if.sink       i_cfg,
    output lpc_pkg::t_cfg o_cfg
);
    import lpc_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_level           <= '0;
            r_cfg.inv_sqrt_averages     <= INV_AVG_RST;
            r_cfg.inv_sqrt_two_averages <= INV_TWO_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NOISE:   r_cfg.noise_level           <= i_cfg.data;
                CFG_INV_AVG: r_cfg.inv_sqrt_averages     <= i_cfg.data[INV_W-1:0];
                CFG_INV_TWO: r_cfg.inv_sqrt_two_averages <= i_cfg.data[INV_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[hw/rtl/lpc_front.sv]
// Input side: lag counter, input register and the reference product stage.
// Depends on lpc_pkg and lpc_lag_if.
module lpc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpc_lag_if.sink         i_lag,
    input  lpc_pkg::t_cfg   i_cfg,
    input  logic            i_take,
    output logic            o_stage_v,
    output lpc_pkg::t_stage o_stage
);
    import lpc_pkg::*;

    logic [LAG_W-1:0] r_lag_cnt;
    logic [LAG_W-1:0] n_lag_cnt;
    logic             r_s1_v;
    logic             r_s2_v;
    t_lag             r_s1;
    t_stage           r_s2;
    logic             accept;
    logic             adv1;
    logic             is_last;
    logic [PROD_W-1:0] prod_avg;
    logic [PROD_W-1:0] prod_two;
    logic [P_W-1:0]   floor_sat;
    logic [P_W-1:0]   offset_sat;

    assign adv1        = r_s1_v && (!r_s2_v || i_take);
    assign i_lag.ready = !r_s1_v || adv1;
    assign accept      = i_lag.valid && i_lag.ready;
    assign is_last     = i_lag.last_lag || (r_lag_cnt == LAG_W'(MAX_LAGS - 1));
    assign n_lag_cnt   = is_last ? '0 : r_lag_cnt + 1'b1;

    // products are only used for the reference lag, but cost nothing to form always
    assign prod_avg   = {{INV_W{1'b0}}, r_s1.power} * {{P_W{1'b0}}, i_cfg.inv_sqrt_averages};
    assign prod_two   = {{INV_W{1'b0}}, r_s1.power} *
                        {{P_W{1'b0}}, i_cfg.inv_sqrt_two_averages};
    assign floor_sat  = prod_avg[PROD_W-1] ? '1 : prod_avg[PROD_W-2:16];
    assign offset_sat = prod_two[PROD_W-1] ? '1 : prod_two[PROD_W-2:16];

    assign o_stage_v = r_s2_v;
    assign o_stage   = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag_cnt <= '0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
        end else begin
            if (accept) begin
                r_lag_cnt <= n_lag_cnt;
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (adv1) begin
                r_s1_v <= 1'b0;
            end
            if (adv1) begin
                r_s2_v <= 1'b1;
            end else if (i_take) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.power       <= i_lag.power;
            r_s1.preset_code <= i_lag.preset_code;
            r_s1.last        <= is_last;
            r_s1.idx         <= r_lag_cnt;
        end
        if (adv1) begin
            r_s2.power       <= r_s1.power;
            r_s2.preset_code <= r_s1.preset_code;
            r_s2.last        <= r_s1.last;
            r_s2.idx         <= r_s1.idx;
            r_s2.floor       <= floor_sat;
            r_s2.offset      <= offset_sat;
        end
    end

endmodule

[hw/rtl/lpc_classify.sv]
// Classification state and logic: holds one lag until its successor arrives.
// Depends on lpc_pkg; feeds up to two results per lag into the output queue.
module lpc_classify (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpc_pkg::t_cfg   i_cfg,
    input  logic            i_stage_v,
    input  lpc_pkg::t_stage i_stage,
    input  logic            i_room,
    output logic            o_take,
    output lpc_pkg::t_push  o_push
);
    import lpc_pkg::*;

    logic [P_W-1:0]     r_floor;
    logic [P_W-1:0]     r_offset;
    logic [BOUND_W-1:0] r_bnow;
    logic [BOUND_W-1:0] r_bbef;
    logic [1:0]         r_flags;
    logic [LAG_W-1:0]   r_pgi;
    logic [GC_W-1:0]    r_tally;
    logic               r_held_v;
    logic [P_W-1:0]     r_held_p;
    logic [CODE_W-1:0]  r_held_code;
    logic [LAG_W-1:0]   r_held_idx;
    logic [BOUND_W-1:0] r_held_bound;

    logic               fire;
    logic               idx0;
    logic [P_W-1:0]     eff_floor;
    logic [P_W-1:0]     eff_offset;
    logic [BOUND_W-1:0] bound_p;
    logic [CODE_W-1:0]  h_code;
    logic               h_rev;
    logic [1:0]         n_flags;
    logic [BOUND_W-1:0] n_bnow;
    logic [BOUND_W-1:0] n_bbef;
    logic [GC_W-1:0]    n_tally;
    logic [LAG_W-1:0]   n_pgi;
    logic [CODE_W-1:0]  x_code;
    logic [GC_W-1:0]    x_tally;

    assign fire   = i_stage_v && i_room;
    assign o_take = fire;

    always_comb begin
        idx0       = (i_stage.idx == '0);
        eff_floor  = idx0 ? i_stage.floor : r_floor;
        eff_offset = idx0 ? i_stage.offset : r_offset;
        bound_p    = make_bound(i_cfg.noise_level, i_stage.power, eff_offset);

        // held lag, with the incoming lag as its successor
        h_code  = r_held_code;
        h_rev   = 1'b0;
        n_flags = r_flags;
        n_bnow  = r_bnow;
        n_bbef  = r_bbef;
        n_tally = r_tally;
        n_pgi   = r_pgi;
        if (r_held_v && r_held_code == CODE_GOOD) begin
            if (r_flags[1]) begin
                h_code = CODE_AFTER_LOWS;
            end else if (r_held_p <= r_floor) begin
                h_code  = CODE_LOW;
                n_flags = {r_flags[0], 1'b1};
            end else begin
                n_flags = '0;
                if ({2'b00, r_held_p} > r_bnow) begin
                    h_code = CODE_HIGH;
                    // spike: lag sits between the two bounds and the next one falls back
                    if ({2'b00, r_held_p} < r_bbef && {2'b00, i_stage.power} > r_bnow &&
                        i_stage.power < r_held_p) begin
                        h_rev  = 1'b1;
                        h_code = CODE_GOOD;
                    end
                end
                n_bbef = r_bnow;
                n_bnow = r_held_bound;
            end
            if (h_code == CODE_GOOD) begin
                n_pgi = r_held_idx;
                if (!h_rev) begin
                    n_tally = r_tally + 1'b1;
                end
            end
        end

        // final lag of a set, classified right away with no successor
        x_code = i_stage.preset_code;
        if (i_stage.preset_code == CODE_GOOD) begin
            if (n_flags[1]) begin
                x_code = CODE_AFTER_LOWS;
            end else if (i_stage.power <= eff_floor) begin
                x_code = CODE_LOW;
            end else if (!idx0 && {2'b00, i_stage.power} > n_bnow) begin
                x_code = CODE_HIGH;
            end
        end
        x_tally = (x_code == CODE_GOOD) ? n_tally + 1'b1 : n_tally;
    end

    always_comb begin
        o_push.a_valid        = fire && r_held_v;
        o_push.a.lag_index    = r_held_idx;
        o_push.a.code         = h_code;
        o_push.a.revise_valid = h_rev;
        o_push.a.revise_lag   = h_rev ? r_pgi : '0;
        o_push.a.good_count   = $signed(n_tally);
        o_push.a.last         = 1'b0;
        o_push.b_valid        = fire && i_stage.last;
        o_push.b.lag_index    = i_stage.idx;
        o_push.b.code         = x_code;
        o_push.b.revise_valid = 1'b0;
        o_push.b.revise_lag   = '0;
        o_push.b.good_count   = $signed(x_tally);
        o_push.b.last         = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= '0;
            r_offset <= '0;
            r_bnow   <= '0;
            r_bbef   <= '0;
            r_flags  <= '0;
            r_pgi    <= '0;
            r_tally  <= '0;
            r_held_v <= 1'b0;
        end else if (fire) begin
            if (i_stage.last) begin
                // set done: drop everything for the next one
                r_floor  <= '0;
                r_offset <= '0;
                r_bnow   <= '0;
                r_bbef   <= '0;
                r_flags  <= '0;
                r_pgi    <= '0;
                r_tally  <= '0;
                r_held_v <= 1'b0;
            end else begin
                r_held_v <= 1'b1;
                r_flags  <= n_flags;
                r_pgi    <= n_pgi;
                r_tally  <= n_tally;
                if (idx0) begin
                    r_floor  <= i_stage.floor;
                    r_offset <= i_stage.offset;
                    r_bnow   <= bound_p;
                    r_bbef   <= bound_p;
                end else begin
                    r_bnow <= n_bnow;
                    r_bbef <= n_bbef;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && !i_stage.last) begin
            r_held_p     <= i_stage.power;
            r_held_code  <= i_stage.preset_code;
            r_held_idx   <= i_stage.idx;
            r_held_bound <= bound_p;
        end
    end

`ifndef SYNTHESIS
    a_no_held_at_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !(r_held_v && i_stage.idx == '0))
        else $error("held lag present when a reference lag arrives");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_stage.last |=> !r_held_v && r_tally == '0 && r_flags == '0)
        else $error("set state not cleared after final lag");

    a_rescue_is_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.a_valid && o_push.a.revise_valid |-> o_push.a.code == CODE_GOOD)
        else $error("revision issued on a lag not rescued to good");
`endif

endmodule

[hw/rtl/lpc_out_queue.sv]
// Result queue: takes up to two results a cycle, drives the result channel.
// Depends on lpc_pkg and lpc_res_if.
module lpc_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpc_pkg::t_push i_push,
    output logic           o_room,
    lpc_res_if.source      o_res
);
    import lpc_pkg::*;

    t_result              r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]  r_wr_ptr;
    logic [OQ_PTR_W-1:0]  r_rd_ptr;
    logic [OQ_CNT_W-1:0]  r_count;
    logic [OQ_PTR_W-1:0]  b_ptr;
    logic                 pop;
    logic [OQ_CNT_W-1:0]  n_count;
    t_result              head;

    assign o_room = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign pop    = o_res.valid && o_res.ready;
    assign b_ptr  = r_wr_ptr + OQ_PTR_W'(i_push.a_valid);
    assign n_count = r_count + OQ_CNT_W'(i_push.a_valid) + OQ_CNT_W'(i_push.b_valid)
                     - OQ_CNT_W'(pop);

    assign head               = r_mem[r_rd_ptr];
    assign o_res.valid        = (r_count != '0);
    assign o_res.lag_index    = head.lag_index;
    assign o_res.code         = head.code;
    assign o_res.revise_valid = head.revise_valid;
    assign o_res.revise_lag   = head.revise_lag;
    assign o_res.good_count   = head.good_count;
    assign o_res.last         = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(i_push.a_valid) + OQ_PTR_W'(i_push.b_valid);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // held lag's result goes first, the final lag's right behind it
    always_ff @(posedge i_clk) begin
        if (i_push.a_valid) begin
            r_mem[r_wr_ptr] <= i_push.a;
        end
        if (i_push.b_valid) begin
            r_mem[b_ptr] <= i_push.b;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue overflow");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        OQ_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[OQ_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.a_valid || i_push.b_valid) |-> r_count <= OQ_CNT_W'(OQ_DEPTH - 2))
        else $error("results pushed without room for two");
`endif

endmodule

[hw/rtl/lag_power_bad_lag_classifier_top.sv]
// Top level of the bad-lag classifier: config registers, front stage,
// classifier and result queue. Depends on lpc_pkg, lpc_if and all lpc_* modules.
//
//  port   dir   role     fields
//  i_lag  in    sink     power, preset_code, last_lag
//  o_res  out   source   lag_index, code, revise_valid, revise_lag, good_count, last
//  i_cfg  in    sink     index, data (0 noise, 1 inv_sqrt_avg, 2 inv_sqrt_two_avg)
//
// One lag request per cycle, sustained while o_res accepts results. A lag passes the
// input and product registers, is classified once its successor reaches the classifier,
// so its result trails by one request; the final lag adds its own result in the same
// cycle. The four-entry result queue gives the classifier a slot only when two are free.
// Synchronous reset clears all set state and restores the register defaults; no sweep.
// Stalls on o_res fill the queue and then back up to i_lag.ready.
module lag_power_bad_lag_classifier_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpc_lag_if.sink    i_lag,
    lpc_cfg_if.sink    i_cfg,
    lpc_res_if.source  o_res
);
    import lpc_pkg::*;

    t_cfg   cfg;
    t_stage stage;
    t_push  push;
    logic   stage_v;
    logic   take;
    logic   room;

    lpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lag     (i_lag),
        .i_cfg     (cfg),
        .i_take    (take),
        .o_stage_v (stage_v),
        .o_stage   (stage)
    );

    lpc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stage_v (stage_v),
        .i_stage   (stage),
        .i_room    (room),
        .o_take    (take),
        .o_push    (push)
    );

    lpc_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule
